FILE: hdl/tfbb_pkg.sv
// Shared constants for the tile frame buffer blitter: stream field layout,
// operation codes, default geometry and the power-up palette.
// No dependencies.
package tfbb_pkg;

    // default geometry
    localparam int DEF_SCREEN_WIDTH  = 300;
    localparam int DEF_SCREEN_HEIGHT = 216;
    localparam int DEF_TILE_WIDTH    = 6;
    localparam int DEF_TILE_HEIGHT   = 12;

    localparam int PIX_W = 4;
    localparam int RGB_W = 24;
    localparam int CH_W  = 8;

    // operation codes (carried in s_tuser)
    localparam int MODE_W = 3;
    localparam logic [MODE_W-1:0] MODE_DRAW       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_XOR        = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CLR_VIEW   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CLR_BORDER = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PAL_WR     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_READ       = 3'd5;

    // input transaction fields in s_tdata, lowest first
    localparam int ROW_W   = 5;
    localparam int COL_W   = 6;
    localparam int LINE_W  = 4;
    localparam int TPIX_W  = 24;
    localparam int COLOR_W = 4;
    localparam int POS_X_W = 9;
    localparam int POS_Y_W = 8;

    localparam int ROW_LSB   = 0;
    localparam int COL_LSB   = ROW_LSB + ROW_W;
    localparam int LINE_LSB  = COL_LSB + COL_W;
    localparam int TPIX_LSB  = LINE_LSB + LINE_W;
    localparam int COLOR_LSB = TPIX_LSB + TPIX_W;
    localparam int RGB_LSB   = COLOR_LSB + COLOR_W;
    localparam int POS_X_LSB = RGB_LSB + RGB_W;
    localparam int POS_Y_LSB = POS_X_LSB + POS_X_W;
    localparam int S_FIELDS_W = POS_Y_LSB + POS_Y_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;

    // result fields in m_tdata, lowest first
    localparam int M_FIELDS_W = PIX_W + 3 * CH_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    function automatic logic [RGB_W-1:0] pal_reset_color(input logic [PIX_W-1:0] idx);
        logic [RGB_W-1:0] c;
        case (idx)
            4'd0:    c = 24'h000000;
            4'd1:    c = 24'h800000;
            4'd2:    c = 24'hFF0000;
            4'd3:    c = 24'hFF00FF;
            4'd4:    c = 24'h008080;
            4'd5:    c = 24'h008000;
            4'd6:    c = 24'h00FF00;
            4'd7:    c = 24'h00FFFF;
            4'd8:    c = 24'h000080;
            4'd9:    c = 24'h800080;
            4'd10:   c = 24'h0000FF;
            4'd11:   c = 24'hC0C0C0;
            4'd12:   c = 24'h808080;
            4'd13:   c = 24'h808000;
            4'd14:   c = 24'hFFFF00;
            default: c = 24'hFFFFFF;
        endcase
        return c;
    endfunction

endpackage

FILE: hdl/tile_frame_buffer_blitter.sv
// Tile frame buffer blitter: 4-bit frame store in one synchronous RAM plus a
// 16-entry RGB palette, driven by a stream of commands.
// Depends on tfbb_pkg.

// The frame store holds one RAM word per tile-wide run of pixels
// (TILE_WIDTH pixels of 4 bits), so a tile line maps onto exactly one word:
// ceil(SCREEN_WIDTH/TILE_WIDTH) words per screen row, 10800 words at the
// default geometry. Every command returns exactly one result transaction;
// only a pixel read (mode 5) returns nonzero data. Draw, xor, palette write,
// read and unused codes: the accept cycle issues the RAM read, the next
// cycle merges and writes back, and the input takes no new command until
// the command has executed. View and border fills walk the whole RAM with a
// read and a write per word. After reset the block zeroes the RAM, one word
// per cycle, with s_tready low. A result waiting in the output register
// does not stop the next command from being accepted when m_tready is high
// in the same cycle.
module tile_frame_buffer_blitter #(
    parameter int SCREEN_WIDTH  = tfbb_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = tfbb_pkg::DEF_SCREEN_HEIGHT,
    parameter int TILE_WIDTH    = tfbb_pkg::DEF_TILE_WIDTH,
    parameter int TILE_HEIGHT   = tfbb_pkg::DEF_TILE_HEIGHT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // tile_row[4:0], tile_col[10:5], tile_line[14:11], tile_pixels[38:15],
    // color[42:39], rgb_value[66:43], pos_x[75:67], pos_y[83:76], zero pad
    input  logic [tfbb_pkg::S_TDATA_W-1:0] s_tdata,
    // mode[2:0]
    input  logic [tfbb_pkg::MODE_W-1:0]    s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // pixel_index[3:0], red[11:4], green[19:12], blue[27:20], zero pad
    output logic [tfbb_pkg::M_TDATA_W-1:0] m_tdata
);
    import tfbb_pkg::*;

    // geometry
    localparam int COLS  = (SCREEN_WIDTH + TILE_WIDTH - 1) / TILE_WIDTH;
    localparam int WORDS = COLS * SCREEN_HEIGHT;
    localparam int AW    = $clog2(WORDS);
    localparam int WW    = TILE_WIDTH * PIX_W;
    localparam int YW    = $clog2(SCREEN_HEIGHT);
    localparam int CW    = $clog2(COLS + 1);
    localparam int PXW   = $clog2((COLS + 64) * TILE_WIDTH + 1);
    localparam int TYW   = $clog2(32 * TILE_HEIGHT + 16);
    localparam int RW    = $clog2(TILE_WIDTH + 1);

    // x / TILE_WIDTH by reciprocal multiply, exact for every 9-bit x
    localparam int RECIP_K = POS_X_W + 4;
    localparam int RECIP_M = ((1 << RECIP_K) + TILE_WIDTH - 1) / TILE_WIDTH;
    localparam int RECIP_W = RECIP_K + 1;
    localparam int PROD_W  = POS_X_W + RECIP_W;

    // sequencer
    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_EXEC   = 3'd2;
    localparam logic [2:0] ST_CLR_RD = 3'd3;
    localparam logic [2:0] ST_CLR_WR = 3'd4;

    logic [2:0] state_reg, state_next;

    // input fields
    logic [ROW_W-1:0]   in_row;
    logic [COL_W-1:0]   in_col;
    logic [LINE_W-1:0]  in_line;
    logic [TPIX_W-1:0]  in_pix;
    logic [COLOR_W-1:0] in_color;
    logic [RGB_W-1:0]   in_rgb;
    logic [POS_X_W-1:0] in_pos_x;
    logic [POS_Y_W-1:0] in_pos_y;

    assign in_row   = s_tdata[ROW_LSB   +: ROW_W];
    assign in_col   = s_tdata[COL_LSB   +: COL_W];
    assign in_line  = s_tdata[LINE_LSB  +: LINE_W];
    assign in_pix   = s_tdata[TPIX_LSB  +: TPIX_W];
    assign in_color = s_tdata[COLOR_LSB +: COLOR_W];
    assign in_rgb   = s_tdata[RGB_LSB   +: RGB_W];
    assign in_pos_x = s_tdata[POS_X_LSB +: POS_X_W];
    assign in_pos_y = s_tdata[POS_Y_LSB +: POS_Y_W];

    logic s_accept;
    assign s_accept = s_tvalid && s_tready;

    // accept-cycle address decode
    logic [TYW-1:0]     acc_y;
    logic               tile_ok;
    logic [AW-1:0]      tile_addr;
    logic [PROD_W-1:0]  rd_prod;
    logic [POS_X_W-1:0] rd_q;
    logic               rd_ok;
    logic [AW-1:0]      rd_addr;
    logic [PXW-1:0]     acc_x0;

    assign acc_y     = TYW'(in_row) * TYW'(TILE_HEIGHT) + TYW'(in_line);
    assign tile_ok   = (in_line < TILE_HEIGHT) && (acc_y < SCREEN_HEIGHT) && (in_col < COLS);
    assign tile_addr = AW'(in_row) * AW'(TILE_HEIGHT * COLS) + AW'(in_line) * AW'(COLS)
                     + AW'(in_col);
    assign rd_prod   = PROD_W'(in_pos_x) * PROD_W'(RECIP_M);
    assign rd_q      = rd_prod[RECIP_K +: POS_X_W];
    assign rd_ok     = (in_pos_x < SCREEN_WIDTH) && (in_pos_y < SCREEN_HEIGHT);
    assign rd_addr   = AW'(in_pos_y) * AW'(COLS) + AW'(rd_q);
    assign acc_x0    = PXW'(in_col) * PXW'(TILE_WIDTH);

    // command held for the execute cycle
    logic [MODE_W-1:0]  mode_reg;
    logic               ok_reg;
    logic [AW-1:0]      addr_reg;
    logic [PXW-1:0]     x0_reg;
    logic [WW-1:0]      pix_reg;
    logic [COLOR_W-1:0] color_reg;
    logic [RGB_W-1:0]   rgb_reg;
    logic [POS_X_W-1:0] q_reg;
    logic [POS_X_W-1:0] posx_reg;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            mode_reg  <= s_tuser;
            ok_reg    <= (s_tuser == MODE_READ) ? rd_ok : tile_ok;
            addr_reg  <= (s_tuser == MODE_READ) ? rd_addr : tile_addr;
            x0_reg    <= acc_x0;
            pix_reg   <= WW'(in_pix);
            color_reg <= in_color;
            rgb_reg   <= in_rgb;
            q_reg     <= rd_q;
            posx_reg  <= in_pos_x;
        end
    end

    // sweep counters: shared by the power-up zeroing and the area fills
    logic [AW-1:0]  sweep_addr_reg, sweep_addr_next;
    logic [CW-1:0]  sweep_col_reg, sweep_col_next;
    logic [PXW-1:0] sweep_x_reg, sweep_x_next;
    logic [YW-1:0]  sweep_y_reg, sweep_y_next;
    logic           sweep_last;
    logic           view_y;

    assign sweep_last = (sweep_addr_reg == AW'(WORDS - 1));
    assign view_y     = (sweep_y_reg >= TILE_HEIGHT) && (sweep_y_reg < SCREEN_HEIGHT - TILE_HEIGHT);

    // frame store RAM
    logic [WW-1:0] frame_mem [WORDS];
    logic [WW-1:0] mem_rdata_reg;
    logic [AW-1:0] mem_raddr;
    logic [AW-1:0] mem_waddr;
    logic [WW-1:0] mem_wdata;
    logic          mem_we;
    logic [WW-1:0] merged;

    assign mem_raddr = (state_reg == ST_IDLE)
                     ? ((s_tuser == MODE_READ) ? rd_addr : tile_addr)
                     : sweep_addr_reg;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = sweep_addr_reg;
        mem_wdata = merged;
        case (state_reg)
            ST_INIT: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
            end
            ST_EXEC: begin
                mem_we    = ok_reg && ((mode_reg == MODE_DRAW) || (mode_reg == MODE_XOR));
                mem_waddr = addr_reg;
            end
            ST_CLR_WR: begin
                mem_we = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            frame_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= frame_mem[mem_raddr];
    end

    // per-pixel merge of the word read last cycle
    logic [PXW-1:0] merge_base;
    logic           fill_view;

    assign merge_base = (state_reg == ST_EXEC) ? x0_reg : sweep_x_reg;
    assign fill_view  = (mode_reg == MODE_CLR_VIEW);

    always_comb begin
        logic [PXW-1:0]   px;
        logic [PIX_W-1:0] old_p;
        logic [PIX_W-1:0] new_p;
        logic             in_view_x;
        logic             sel;
        merged = mem_rdata_reg;
        for (int i = 0; i < TILE_WIDTH; i++) begin
            px        = merge_base + PXW'(i);
            old_p     = mem_rdata_reg[i*PIX_W +: PIX_W];
            in_view_x = (px >= TILE_WIDTH) && (px < SCREEN_WIDTH - TILE_WIDTH);
            if (state_reg == ST_EXEC) begin
                sel   = (px < SCREEN_WIDTH);
                new_p = (mode_reg == MODE_XOR) ? (old_p ^ pix_reg[i*PIX_W +: PIX_W])
                                               : pix_reg[i*PIX_W +: PIX_W];
            end else begin
                sel   = (px < SCREEN_WIDTH) && ((in_view_x && view_y) == fill_view);
                new_p = color_reg;
            end
            merged[i*PIX_W +: PIX_W] = sel ? new_p : old_p;
        end
    end

    // palette
    logic [RGB_W-1:0] palette_reg [16];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 16; i++) begin
                palette_reg[i] <= pal_reset_color(PIX_W'(i));
            end
        end else if (state_reg == ST_EXEC && mode_reg == MODE_PAL_WR) begin
            palette_reg[color_reg] <= rgb_reg;
        end
    end

    // pixel read: remainder of x / TILE_WIDTH picks the nibble
    logic [POS_X_W-1:0] rd_diff;
    logic [RW-1:0]      rd_rem;
    logic [PIX_W-1:0]   rd_nib;
    logic [PIX_W-1:0]   rd_pix;
    logic [RGB_W-1:0]   rd_rgb;
    logic               rd_active;

    assign rd_diff   = posx_reg - POS_X_W'(q_reg * POS_X_W'(TILE_WIDTH));
    assign rd_rem    = RW'(rd_diff);
    assign rd_nib    = PIX_W'(mem_rdata_reg >> (rd_rem * PIX_W));
    assign rd_active = (mode_reg == MODE_READ) && ok_reg;
    assign rd_pix    = rd_active ? rd_nib : '0;
    assign rd_rgb    = rd_active ? palette_reg[rd_pix] : '0;

    // result register
    logic                 out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;

    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb begin
        state_next      = state_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_col_next  = sweep_col_reg;
        sweep_x_next    = sweep_x_reg;
        sweep_y_next    = sweep_y_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        case (state_reg)
            ST_INIT: begin
                sweep_addr_next = sweep_addr_reg + AW'(1);
                if (sweep_last) begin
                    sweep_addr_next = '0;
                    state_next      = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    sweep_addr_next = '0;
                    sweep_col_next  = '0;
                    sweep_x_next    = '0;
                    sweep_y_next    = '0;
                    if (s_tuser == MODE_CLR_VIEW || s_tuser == MODE_CLR_BORDER) begin
                        state_next = ST_CLR_RD;
                    end else begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_EXEC: begin
                out_valid_next = 1'b1;
                out_data_next  = M_TDATA_W'({rd_rgb[7:0], rd_rgb[15:8], rd_rgb[23:16], rd_pix});
                state_next     = ST_IDLE;
            end
            ST_CLR_RD: begin
                state_next = ST_CLR_WR;
            end
            ST_CLR_WR: begin
                sweep_addr_next = sweep_addr_reg + AW'(1);
                if (sweep_col_reg == CW'(COLS - 1)) begin
                    sweep_col_next = '0;
                    sweep_x_next   = '0;
                    sweep_y_next   = sweep_y_reg + YW'(1);
                end else begin
                    sweep_col_next = sweep_col_reg + CW'(1);
                    sweep_x_next   = sweep_x_reg + PXW'(TILE_WIDTH);
                end
                if (sweep_last) begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    state_next     = ST_IDLE;
                end else begin
                    state_next = ST_CLR_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_INIT;
            sweep_addr_reg <= '0;
            sweep_col_reg  <= '0;
            sweep_x_reg    <= '0;
            sweep_y_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_col_reg  <= sweep_col_next;
            sweep_x_reg    <= sweep_x_next;
            sweep_y_reg    <= sweep_y_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    // checks
    a_accept_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |-> (!out_valid_reg || m_tready))
        else $error("command accepted while result slot stays full");

    a_no_write_on_read: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |-> !mem_we)
        else $error("RAM written in the cycle a new command reads it");

    a_exec_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC) |=> out_valid_reg)
        else $error("execute cycle produced no result transaction");

    a_waddr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (mem_waddr <= AW'(WORDS - 1)))
        else $error("frame store write beyond last word");

endmodule

FILE: verif/tb_tile_frame_buffer_blitter.sv
// Self-checking testbench for tile_frame_buffer_blitter: directed corner cases,
// then a long random command stream with stalls on both stream channels.
// Depends on tfbb_pkg and the DUT; stands alone otherwise.

typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [3:0] idx;
} pixel_result_t;

// Mirror of the frame store and palette; accepted commands update it, and each
// queues the result transaction the block owes for it.
class frame_mirror;
    localparam int SW = tfbb_pkg::DEF_SCREEN_WIDTH;
    localparam int SH = tfbb_pkg::DEF_SCREEN_HEIGHT;
    localparam int TW = tfbb_pkg::DEF_TILE_WIDTH;
    localparam int TH = tfbb_pkg::DEF_TILE_HEIGHT;

    bit [3:0]      store [SW*SH];
    bit [23:0]     colors [16];
    pixel_result_t due_results [$];
    int            mismatches;
    int            checked;

    function new();
        foreach (store[i]) store[i] = '0;
        colors = '{24'h000000, 24'h800000, 24'hFF0000, 24'hFF00FF,
                   24'h008080, 24'h008000, 24'h00FF00, 24'h00FFFF,
                   24'h000080, 24'h800080, 24'h0000FF, 24'hC0C0C0,
                   24'h808080, 24'h808000, 24'hFFFF00, 24'hFFFFFF};
        mismatches = 0;
        checked    = 0;
    endfunction

    function int outstanding();
        return due_results.size();
    endfunction

    function void note_command(logic [2:0] mode, logic [tfbb_pkg::S_TDATA_W-1:0] d);
        int unsigned   row, col, line, px, py, x, y;
        bit [23:0]     pix;
        bit [3:0]      color;
        bit            view_x, view_y, want_view;
        pixel_result_t want;
        row   = 32'(d[tfbb_pkg::ROW_LSB +: tfbb_pkg::ROW_W]);
        col   = 32'(d[tfbb_pkg::COL_LSB +: tfbb_pkg::COL_W]);
        line  = 32'(d[tfbb_pkg::LINE_LSB +: tfbb_pkg::LINE_W]);
        pix   = d[tfbb_pkg::TPIX_LSB +: tfbb_pkg::TPIX_W];
        color = d[tfbb_pkg::COLOR_LSB +: tfbb_pkg::COLOR_W];
        px    = 32'(d[tfbb_pkg::POS_X_LSB +: tfbb_pkg::POS_X_W]);
        py    = 32'(d[tfbb_pkg::POS_Y_LSB +: tfbb_pkg::POS_Y_W]);
        want  = '0;
        case (mode)
            tfbb_pkg::MODE_DRAW, tfbb_pkg::MODE_XOR: begin
                // lines past the tile height and rows below the screen are dropped
                y = row * TH + line;
                if (line < TH && y < SH) begin
                    for (int i = 0; i < TW; i++) begin
                        x = col * TW + i;
                        if (x < SW) begin
                            if (mode == tfbb_pkg::MODE_XOR)
                                store[y*SW + x] ^= pix[4*i +: 4];
                            else
                                store[y*SW + x] = pix[4*i +: 4];
                        end
                    end
                end
            end
            tfbb_pkg::MODE_CLR_VIEW, tfbb_pkg::MODE_CLR_BORDER: begin
                want_view = (mode == tfbb_pkg::MODE_CLR_VIEW);
                for (int yy = 0; yy < SH; yy++) begin
                    view_y = (yy >= TH) && (yy < SH - TH);
                    for (int xx = 0; xx < SW; xx++) begin
                        view_x = (xx >= TW) && (xx < SW - TW);
                        if ((view_x && view_y) == want_view)
                            store[yy*SW + xx] = color;
                    end
                end
            end
            tfbb_pkg::MODE_PAL_WR: colors[color] = d[tfbb_pkg::RGB_LSB +: tfbb_pkg::RGB_W];
            tfbb_pkg::MODE_READ: begin
                // off-screen reads return all zero
                if (px < SW && py < SH) begin
                    want.idx = store[py*SW + px];
                    {want.red, want.green, want.blue} = colors[want.idx];
                end
            end
            default: ;
        endcase
        due_results.push_back(want);
    endfunction

    function void check_result(logic [tfbb_pkg::M_TDATA_W-1:0] t);
        pixel_result_t got, want;
        got = t[tfbb_pkg::M_FIELDS_W-1:0];
        if (due_results.size() == 0) begin
            $display("%0t: result with none expected: expected nothing, got %h", $time, t);
            mismatches++;
            return;
        end
        want = due_results.pop_front();
        checked++;
        if (got.idx !== want.idx) begin
            $display("%0t: pixel_index expected %0h got %0h", $time, want.idx, got.idx);
            mismatches++;
        end
        if (got.red !== want.red) begin
            $display("%0t: red expected %02h got %02h", $time, want.red, got.red);
            mismatches++;
        end
        if (got.green !== want.green) begin
            $display("%0t: green expected %02h got %02h", $time, want.green, got.green);
            mismatches++;
        end
        if (got.blue !== want.blue) begin
            $display("%0t: blue expected %02h got %02h", $time, want.blue, got.blue);
            mismatches++;
        end
    endfunction
endclass

module tb_tile_frame_buffer_blitter;
    import tfbb_pkg::*;

    localparam int SW = DEF_SCREEN_WIDTH;
    localparam int SH = DEF_SCREEN_HEIGHT;
    localparam int TW = DEF_TILE_WIDTH;
    localparam int TH = DEF_TILE_HEIGHT;

    // codes the block must answer with an all-zero result
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    localparam int RANDOM_ITEMS = 1800;
    localparam int CALM_ITEMS   = 200;     // tail of the run with no stalls
    localparam int TAIL_CYCLES  = 50;      // watch for stray results at the end
    // Worst case: the RAM zeroing, ~1850 commands each eating a longest sender
    // gap and a longest receiver stall, plus ~40 fills (rare fill picks and fill
    // codes in the random noise) that each walk the whole RAM. Several times that:
    localparam int CYCLE_LIMIT  = 6_000_000;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [MODE_W-1:0]    s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b1;
    logic [M_TDATA_W-1:0] m_tdata;

    frame_mirror mirror = new();

    bit          calm = 1'b0;
    int          cycles = 0;
    int          mode_seen [8] = '{default: 0};
    int unsigned last_x = 0;
    int unsigned last_y = 0;

    tile_frame_buffer_blitter i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, mirror.outstanding());
            $display("tile_frame_buffer_blitter regression: fail");
            $finish;
        end
    end

    // Both channels are observed at the rising edge; a transaction is taken
    // when tvalid and tready are high together.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            mirror.note_command(s_tuser, s_tdata);
            mode_seen[s_tuser]++;
        end
        if (aresetn && m_tvalid && m_tready)
            mirror.check_result(m_tdata);
    end

    // Receiver: random stall bursts until the calm tail begins.
    initial begin
        forever begin
            @(negedge aclk);
            if (!calm && $urandom_range(0, 9) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    // Every field random, pad bits zero; callers overwrite what they use so
    // the don't-care fields still toggle.
    function automatic logic [S_TDATA_W-1:0] rand_fields();
        logic [95:0]          bits;
        logic [S_TDATA_W-1:0] d;
        bits = {$urandom(), $urandom(), $urandom()};
        d = bits[S_TDATA_W-1:0];
        for (int i = S_FIELDS_W; i < S_TDATA_W; i++)
            d[i] = 1'b0;
        return d;
    endfunction

    // Hold the transaction until accepted; returns on the following falling
    // edge with tvalid still high.
    task automatic issue(input logic [MODE_W-1:0] mode, input logic [S_TDATA_W-1:0] d);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic put_line(input logic [MODE_W-1:0] mode, input int unsigned row,
                            input int unsigned col, input int unsigned line,
                            input logic [23:0] pix);
        logic [S_TDATA_W-1:0] d;
        d = rand_fields();
        d[ROW_LSB +: ROW_W]   = ROW_W'(row);
        d[COL_LSB +: COL_W]   = COL_W'(col);
        d[LINE_LSB +: LINE_W] = LINE_W'(line);
        d[TPIX_LSB +: TPIX_W] = pix;
        issue(mode, d);
    endtask

    task automatic fill(input logic [MODE_W-1:0] mode, input logic [3:0] color);
        logic [S_TDATA_W-1:0] d;
        d = rand_fields();
        d[COLOR_LSB +: COLOR_W] = color;
        issue(mode, d);
    endtask

    task automatic set_color(input logic [3:0] slot, input logic [23:0] rgb);
        logic [S_TDATA_W-1:0] d;
        d = rand_fields();
        d[COLOR_LSB +: COLOR_W] = slot;
        d[RGB_LSB +: RGB_W]     = rgb;
        issue(MODE_PAL_WR, d);
    endtask

    task automatic peek(input int unsigned x, input int unsigned y);
        logic [S_TDATA_W-1:0] d;
        d = rand_fields();
        d[POS_X_LSB +: POS_X_W] = POS_X_W'(x);
        d[POS_Y_LSB +: POS_Y_W] = POS_Y_W'(y);
        issue(MODE_READ, d);
    endtask

    // Drop tvalid and hold off until every owed result has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (mirror.outstanding() != 0) @(negedge aclk);
    endtask

    initial begin
        int unsigned pick, row, col, line;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // --- directed: reset contents, tile edges, dropped lines, reads off screen
        peek(0, 0);
        put_line(MODE_DRAW, 0, 0, 0, 24'h654321);
        peek(0, 0);
        peek(5, 0);
        put_line(MODE_XOR, 0, 0, 0, 24'hFFFFFF);
        peek(2, 0);
        put_line(MODE_DRAW, 17, 49, 11, 24'hFFFFFF);     // bottom-right tile line
        put_line(MODE_DRAW, 0, 50, 0, 24'hAAAAAA);       // starts past right edge
        put_line(MODE_DRAW, 31, 63, 15, 24'h123456);     // every field at its top
        put_line(MODE_DRAW, 0, 1, 12, 24'h777777);       // line beyond tile height
        put_line(MODE_XOR, 18, 0, 0, 24'h999999);        // row below the screen
        peek(TW, 0);
        set_color(15, 24'h000000);
        set_color(0, 24'hFFFFFF);
        peek(SW - 1, SH - 1);
        peek(SW, 0);
        peek(511, 255);
        peek(0, SH);
        issue(MODE_SPARE_LO, rand_fields());
        issue(MODE_SPARE_HI, rand_fields());
        fill(MODE_CLR_VIEW, 9);
        peek(TW, TH);
        peek(TW - 1, TH);
        fill(MODE_CLR_BORDER, 3);
        peek(0, 0);
        peek(SW - TW - 1, SH - TH - 1);
        peek(SW - TW, SH - TH - 1);

        // --- random: mostly on-screen tile lines and read-backs near them,
        // with palette writes, rare fills and fully random noise mixed in
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            if (n == RANDOM_ITEMS / 2)
                drain();
            pick = $urandom_range(0, 999);
            if (pick < 8) begin
                fill(pick < 4 ? MODE_CLR_VIEW : MODE_CLR_BORDER, 4'($urandom_range(0, 15)));
            end else if (pick < 60) begin
                issue(MODE_W'($urandom_range(0, 7)), rand_fields());
            end else if (pick < 110) begin
                set_color(4'($urandom_range(0, 15)), 24'($urandom()));
            end else if (pick < 520) begin
                row  = $urandom_range(0, SH / TH - 1);
                col  = $urandom_range(0, SW / TW - 1);
                line = $urandom_range(0, TH - 1);
                put_line($urandom_range(0, 3) == 0 ? MODE_XOR : MODE_DRAW,
                         row, col, line, 24'($urandom()));
                last_x = col * TW;
                last_y = row * TH + line;
            end else if ($urandom_range(0, 9) < 7) begin
                peek(last_x + $urandom_range(0, TW - 1), last_y);
            end else begin
                peek($urandom_range(0, SW - 1), $urandom_range(0, SH - 1));
            end
            if (!calm && $urandom_range(0, 7) == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge aclk);
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("commands: %0d draw, %0d xor, %0d view fill, %0d border fill, %0d palette",
                 mode_seen[MODE_DRAW], mode_seen[MODE_XOR], mode_seen[MODE_CLR_VIEW],
                 mode_seen[MODE_CLR_BORDER], mode_seen[MODE_PAL_WR]);
        $display("          %0d pixel reads, %0d unused codes; %0d results checked",
                 mode_seen[MODE_READ], mode_seen[MODE_SPARE_LO] + mode_seen[MODE_SPARE_HI],
                 mirror.checked);
        if (mirror.mismatches == 0 && mirror.outstanding() == 0) begin
            $display("tile_frame_buffer_blitter regression: pass");
        end else begin
            $display("tile_frame_buffer_blitter regression: fail");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/tfbb_pkg.sv
hdl/tile_frame_buffer_blitter.sv
verif/tb_tile_frame_buffer_blitter.sv
